// ===== design/dds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants for the differential-drive slew mixer.
// ----------------------------------------------------------------------------
package dds_pkg;

    localparam int MAX_WHEELS   = 4;
    localparam int NUM_WHEELS_D = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DEND_W = 44;
    localparam int DSOR_W = 29;
    localparam int QUO_W  = 16;

    localparam logic [15:0] TIMEOUT_RST   = 16'd500;
    localparam logic [14:0] SPEED_STEP_RST = 15'd20;
    localparam logic [14:0] YAW_STEP_RST  = 15'd50;
    localparam logic [11:0] TRACK_RST     = 12'd200;
    localparam logic [14:0] WHEEL_MAX_RST = 15'd1000;
    localparam logic [3:0]  LEFT_MASK_RST = 4'd3;

    localparam logic [10:0] MIX_SCALE = 11'd2000;
    localparam logic [9:0]  YAW_SCALE = 10'd1000;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_STOP = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_TIMEOUT    = 3'd0,
        REG_SPEED_STEP = 3'd1,
        REG_YAW_STEP   = 3'd2,
        REG_TRACK      = 3'd3,
        REG_WHEEL_MAX  = 3'd4,
        REG_LEFT_MASK  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_LEFT  = 2'd0,
        DIV_RIGHT = 2'd1,
        DIV_SPEED = 2'd2,
        DIV_YAW   = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     apply;
        logic     watch;
        logic     prod;
        logic     mix;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic div_busy;
    } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== design/diff_drive_slew_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_slew_mixer
// Differential-drive command watchdog, slew ramps, wheel mixing and clamp,
// and body velocity rebuilt from measured wheel speeds.
// ----------------------------------------------------------------------------
// Sequencing: a tick item runs the watchdog, product and mix steps, then
// four passes through the shared 16-step divider (left, right, speed, yaw);
// set, stop and the unused code take only the apply step.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is registered.
// Reset: asynchronous, active low; registers return to their defaults, the
// watchdog reads tripped, ramps, command and stored results clear.
// ----------------------------------------------------------------------------
module diff_drive_slew_mixer
#(
    parameter int NUM_WHEELS = dds_pkg::NUM_WHEELS_D
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [dds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dds_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        operation,
    input  wire logic signed [15:0]                cmd_speed,
    input  wire logic signed [15:0]                cmd_yaw,
    input  wire logic [31:0]                       now_ms,
    input  wire logic signed [15:0]                wheel_speed_0,
    input  wire logic signed [15:0]                wheel_speed_1,
    input  wire logic signed [15:0]                wheel_speed_2,
    input  wire logic signed [15:0]                wheel_speed_3,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [15:0]                     target_left,
    output logic signed [15:0]                     target_right,
    output logic signed [15:0]                     measured_speed,
    output logic signed [15:0]                     measured_yaw,
    output logic                                   watchdog_tripped
);

    dds_pkg::ctrl_cmd_t  cmd;
    dds_pkg::ctrl_stat_t stat;

    dds_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dds_dp #(
        .NUM_WHEELS (NUM_WHEELS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .cmd_speed        (cmd_speed),
        .cmd_yaw          (cmd_yaw),
        .now_ms           (now_ms),
        .wheel_speed_0    (wheel_speed_0),
        .wheel_speed_1    (wheel_speed_1),
        .wheel_speed_2    (wheel_speed_2),
        .wheel_speed_3    (wheel_speed_3),
        .target_left      (target_left),
        .target_right     (target_right),
        .measured_speed   (measured_speed),
        .measured_yaw     (measured_yaw),
        .watchdog_tripped (watchdog_tripped)
    );

endmodule
`default_nettype wire

// ===== design/dds_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dds_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dds_pkg::DEND_W-1:0]   dividend,
    input  wire logic [dds_pkg::DSOR_W-1:0]   divisor,
    output logic      [dds_pkg::QUO_W-1:0]    quotient,
    output logic                              busy
);

    localparam int QW = dds_pkg::QUO_W;
    localparam int DW = dds_pkg::DSOR_W;

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [DW-1:0] dsor_reg;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, low_reg[QW-1]};
        diff      = trial - {1'b0, dsor_reg};
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                low_next = {low_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                low_next = {low_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(QW);
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DW'(dividend[dds_pkg::DEND_W-1:QW]);
            low_reg  <= dividend[QW-1:0];
            dsor_reg <= divisor;
        end
        else
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign quotient = low_reg;
    assign busy     = busy_reg;

endmodule
`default_nettype wire

// ===== design/dds_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_ctrl
// Sequencer: accepts items, steps the datapath, drives the output handshake.
// ----------------------------------------------------------------------------
module dds_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire dds_pkg::ctrl_stat_t stat,
    output dds_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_WATCH,
        S_PROD,
        S_MIX,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    dds_pkg::div_sel_t sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cmd            = '0;
        cmd.div_sel    = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (stat.op == dds_pkg::OP_TICK)
                begin
                    state_next = S_WATCH;
                end
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_WATCH:
            begin
                cmd.watch  = 1'b1;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                sel_next   = dds_pkg::DIV_LEFT;
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (!stat.div_busy)
                begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == dds_pkg::DIV_YAW)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sel_next   = dds_pkg::div_sel_t'(sel_reg + 2'd1);
                        state_next = S_DIV_LOAD;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= dds_pkg::DIV_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== design/dds_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_dp
// Datapath: configuration, command state, ramps, mixing, measures, divider.
// ----------------------------------------------------------------------------
module dds_dp
#(
    parameter int NUM_WHEELS = dds_pkg::NUM_WHEELS_D
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dds_pkg::ctrl_cmd_t                cmd,
    output dds_pkg::ctrl_stat_t                    stat,
    input  wire logic                              cfg_we,
    input  wire logic [dds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dds_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [1:0]                        operation,
    input  wire logic signed [15:0]                cmd_speed,
    input  wire logic signed [15:0]                cmd_yaw,
    input  wire logic [31:0]                       now_ms,
    input  wire logic signed [15:0]                wheel_speed_0,
    input  wire logic signed [15:0]                wheel_speed_1,
    input  wire logic signed [15:0]                wheel_speed_2,
    input  wire logic signed [15:0]                wheel_speed_3,
    output logic signed [15:0]                     target_left,
    output logic signed [15:0]                     target_right,
    output logic signed [15:0]                     measured_speed,
    output logic signed [15:0]                     measured_yaw,
    output logic                                   watchdog_tripped
);

    localparam int NW = dds_pkg::MAX_WHEELS;
    localparam logic [28:0] MIX_SCALE_W = 29'(dds_pkg::MIX_SCALE);
    localparam int DEND_W_T = dds_pkg::DEND_W;

    // configuration
    logic [15:0] timeout_reg;
    logic [14:0] speed_step_reg;
    logic [14:0] yaw_step_reg;
    logic [11:0] track_reg;
    logic [14:0] wheel_max_reg;
    logic [3:0]  left_mask_reg;

    // captured item
    dds_pkg::op_t       op_reg;
    logic signed [15:0] in_speed_reg;
    logic signed [15:0] in_yaw_reg;
    logic [31:0]        now_reg;
    logic signed [15:0] wheel_reg [NW];

    // persistent state
    logic signed [15:0] held_s_reg;
    logic signed [15:0] held_y_reg;
    logic [31:0]        stamp_reg;
    logic               seen_reg;
    logic signed [15:0] ramp_s_reg;
    logic signed [15:0] ramp_y_reg;
    logic               tripped_reg;
    logic signed [15:0] last_l_reg;
    logic signed [15:0] last_r_reg;
    logic signed [15:0] last_sp_reg;
    logic signed [15:0] last_yw_reg;

    // working registers
    logic signed [17:0] sum_l_reg, sum_r_reg;
    logic [2:0]         n_l_reg, n_r_reg;
    logic signed [29:0] p_s_reg, p_y_reg;
    logic signed [21:0] a_reg, b_reg;
    logic [5:0]         den_reg;
    logic signed [29:0] l_reg, r_reg;
    logic [28:0]        peak_reg;
    logic               clamp_reg;
    logic signed [22:0] sumab_reg;
    logic signed [32:0] dyn_reg;
    logic [17:0]        dyaw_reg;
    logic [6:0]         dsp_reg;
    logic               neg_reg;

    // watchdog and slew
    logic [31:0]        age;
    logic               stale;
    logic signed [15:0] base_s, base_y, want_s, want_y;
    logic signed [15:0] ramp_s_next, ramp_y_next;
    logic signed [17:0] sum_l_next, sum_r_next;
    logic [2:0]         n_l_next, n_r_next;

    // mixing
    logic signed [29:0] l_next, r_next;
    logic [28:0]        l_mag, r_mag, peak_next;
    logic               clamp_next;

    // division operands
    logic [31:0]                    ymag;
    logic                           ysat;
    logic [22:0]                    smag;
    logic [28:0]                    sel_mag;
    logic                           sel_neg;
    logic [dds_pkg::DEND_W-1:0]     dend;
    logic [dds_pkg::DSOR_W-1:0]     dsor;
    logic [dds_pkg::QUO_W-1:0]      quo;
    logic                           div_busy;
    logic signed [15:0]             q_signed;

    function automatic logic signed [15:0] slew
    (
        input logic signed [15:0] cur,
        input logic signed [15:0] want,
        input logic [14:0]        step
    );
        logic signed [16:0] d;
        logic signed [16:0] s;
        d = 17'(want) - 17'(cur);
        s = $signed({2'b00, step});
        if (d > s)
            slew = 16'(17'(cur) + s);
        else if (d < -s)
            slew = 16'(17'(cur) - s);
        else
            slew = want;
    endfunction

    always_comb
    begin
        age    = now_reg - stamp_reg;
        stale  = !seen_reg || (age > {16'b0, timeout_reg});
        base_s = (stale && !tripped_reg) ? 16'sd0 : ramp_s_reg;
        base_y = (stale && !tripped_reg) ? 16'sd0 : ramp_y_reg;
        want_s = stale ? 16'sd0 : held_s_reg;
        want_y = stale ? 16'sd0 : held_y_reg;
        ramp_s_next = slew(base_s, want_s, speed_step_reg);
        ramp_y_next = slew(base_y, want_y, yaw_step_reg);

        sum_l_next = '0;
        sum_r_next = '0;
        n_l_next   = '0;
        n_r_next   = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (i < NUM_WHEELS)
            begin
                if (left_mask_reg[i])
                begin
                    sum_l_next = sum_l_next + 18'(wheel_reg[i]);
                    n_l_next   = n_l_next + 3'd1;
                end
                else
                begin
                    sum_r_next = sum_r_next + 18'(wheel_reg[i]);
                    n_r_next   = n_r_next + 3'd1;
                end
            end
        end
        if (n_l_next == 3'd0)
            n_l_next = 3'd1;
        if (n_r_next == 3'd0)
            n_r_next = 3'd1;
    end

    always_comb
    begin
        l_next     = p_s_reg - p_y_reg;
        r_next     = p_s_reg + p_y_reg;
        l_mag      = l_next[29] ? 29'(-l_next) : l_next[28:0];
        r_mag      = r_next[29] ? 29'(-r_next) : r_next[28:0];
        peak_next  = (l_mag > r_mag) ? l_mag : r_mag;
        clamp_next = peak_next > (29'(wheel_max_reg) * 29'(MIX_SCALE_W));
    end

    always_comb
    begin
        ymag = dyn_reg[32] ? 32'(-dyn_reg) : dyn_reg[31:0];
        ysat = {1'b0, ymag} >= {dyaw_reg, 15'b0};
        smag = sumab_reg[22] ? 23'(-sumab_reg) : sumab_reg[22:0];
        sel_mag = '0;
        sel_neg = 1'b0;
        dend    = '0;
        dsor    = '0;
        unique case (cmd.div_sel)
            dds_pkg::DIV_LEFT, dds_pkg::DIV_RIGHT:
            begin
                if (cmd.div_sel == dds_pkg::DIV_LEFT)
                begin
                    sel_mag = l_reg[29] ? 29'(-l_reg) : l_reg[28:0];
                    sel_neg = l_reg[29];
                end
                else
                begin
                    sel_mag = r_reg[29] ? 29'(-r_reg) : r_reg[28:0];
                    sel_neg = r_reg[29];
                end
                dend = DEND_W_T'(sel_mag) *
                       DEND_W_T'(clamp_reg ? wheel_max_reg : 15'd1);
                dsor = clamp_reg ? peak_reg : MIX_SCALE_W;
            end
            dds_pkg::DIV_SPEED:
            begin
                dend    = dds_pkg::DEND_W'(smag);
                dsor    = dds_pkg::DSOR_W'(dsp_reg);
                sel_neg = sumab_reg[22];
            end
            dds_pkg::DIV_YAW:
            begin
                dend    = dds_pkg::DEND_W'(ymag);
                dsor    = dds_pkg::DSOR_W'(dyaw_reg);
                sel_neg = dyn_reg[32];
            end
            default:
            begin
                dend = '0;
            end
        endcase
        q_signed = neg_reg ? 16'(-quo) : quo;
    end

    dds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dend),
        .divisor  (dsor),
        .quotient (quo),
        .busy     (div_busy)
    );

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= dds_pkg::TIMEOUT_RST;
            speed_step_reg <= dds_pkg::SPEED_STEP_RST;
            yaw_step_reg   <= dds_pkg::YAW_STEP_RST;
            track_reg      <= dds_pkg::TRACK_RST;
            wheel_max_reg  <= dds_pkg::WHEEL_MAX_RST;
            left_mask_reg  <= dds_pkg::LEFT_MASK_RST;
            held_s_reg     <= '0;
            held_y_reg     <= '0;
            stamp_reg      <= '0;
            seen_reg       <= 1'b0;
            ramp_s_reg     <= '0;
            ramp_y_reg     <= '0;
            tripped_reg    <= 1'b1;
            last_l_reg     <= '0;
            last_r_reg     <= '0;
            last_sp_reg    <= '0;
            last_yw_reg    <= '0;
            op_reg         <= dds_pkg::OP_NOP;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dds_pkg::REG_TIMEOUT:    timeout_reg    <= cfg_data;
                    dds_pkg::REG_SPEED_STEP: speed_step_reg <= cfg_data[14:0];
                    dds_pkg::REG_YAW_STEP:   yaw_step_reg   <= cfg_data[14:0];
                    dds_pkg::REG_TRACK:      track_reg      <= cfg_data[11:0];
                    dds_pkg::REG_WHEEL_MAX:  wheel_max_reg  <= cfg_data[14:0];
                    dds_pkg::REG_LEFT_MASK:  left_mask_reg  <= cfg_data[3:0];
                    default:                 timeout_reg    <= timeout_reg;
                endcase
            end
            if (cmd.load_in)
                op_reg <= dds_pkg::op_t'(operation);
            if (cmd.apply)
            begin
                case (op_reg)
                    dds_pkg::OP_SET:
                    begin
                        held_s_reg <= in_speed_reg;
                        held_y_reg <= in_yaw_reg;
                        stamp_reg  <= now_reg;
                        seen_reg   <= 1'b1;
                    end
                    dds_pkg::OP_STOP:
                    begin
                        held_s_reg <= '0;
                        held_y_reg <= '0;
                        ramp_s_reg <= '0;
                        ramp_y_reg <= '0;
                        last_l_reg <= '0;
                        last_r_reg <= '0;
                    end
                    default:
                    begin
                        seen_reg <= seen_reg;
                    end
                endcase
            end
            if (cmd.watch)
            begin
                tripped_reg <= stale;
                ramp_s_reg  <= ramp_s_next;
                ramp_y_reg  <= ramp_y_next;
            end
            if (cmd.div_store)
            begin
                case (cmd.div_sel)
                    dds_pkg::DIV_LEFT:  last_l_reg  <= q_signed;
                    dds_pkg::DIV_RIGHT: last_r_reg  <= q_signed;
                    dds_pkg::DIV_SPEED: last_sp_reg <= q_signed;
                    default:
                    begin
                        if (track_reg == 12'd0)
                            last_yw_reg <= '0;
                        else if (ysat)
                            last_yw_reg <= neg_reg ? 16'sh8000 : 16'sh7FFF;
                        else
                            last_yw_reg <= q_signed;
                    end
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_speed_reg <= cmd_speed;
            in_yaw_reg   <= cmd_yaw;
            now_reg      <= now_ms;
            wheel_reg[0] <= wheel_speed_0;
            wheel_reg[1] <= wheel_speed_1;
            wheel_reg[2] <= wheel_speed_2;
            wheel_reg[3] <= wheel_speed_3;
        end
        if (cmd.watch)
        begin
            sum_l_reg <= sum_l_next;
            sum_r_reg <= sum_r_next;
            n_l_reg   <= n_l_next;
            n_r_reg   <= n_r_next;
        end
        if (cmd.prod)
        begin
            p_s_reg <= ramp_s_reg * 30'sd2000;
            p_y_reg <= ramp_y_reg * $signed({18'b0, track_reg});
            a_reg   <= sum_l_reg * $signed({1'b0, n_r_reg});
            b_reg   <= sum_r_reg * $signed({1'b0, n_l_reg});
            den_reg <= 6'(n_l_reg) * 6'(n_r_reg);
        end
        if (cmd.mix)
        begin
            l_reg     <= l_next;
            r_reg     <= r_next;
            peak_reg  <= peak_next;
            clamp_reg <= clamp_next;
            sumab_reg <= 23'(a_reg) + 23'(b_reg);
            dyn_reg   <= (33'(b_reg) - 33'(a_reg)) * $signed({23'b0, dds_pkg::YAW_SCALE});
            dyaw_reg  <= 18'(den_reg) * 18'(track_reg);
            dsp_reg   <= {den_reg, 1'b0};
        end
        if (cmd.div_start)
            neg_reg <= sel_neg;
        if (cmd.load_out)
        begin
            target_left      <= last_l_reg;
            target_right     <= last_r_reg;
            measured_speed   <= last_sp_reg;
            measured_yaw     <= last_yw_reg;
            watchdog_tripped <= tripped_reg;
        end
    end

    assign stat = '{op: op_reg, div_busy: div_busy};

endmodule
`default_nettype wire

// ===== test/dds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_checker
// Watches the item and result channels of the slew mixer, predicts every
// result from its own copy of the state and registers, and compares.
// ----------------------------------------------------------------------------
module dds_checker
    import dds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic signed [15:0]    cmd_speed,
    input  logic signed [15:0]    cmd_yaw,
    input  logic [31:0]           now_ms,
    input  logic signed [15:0]    wheel_speed_0,
    input  logic signed [15:0]    wheel_speed_1,
    input  logic signed [15:0]    wheel_speed_2,
    input  logic signed [15:0]    wheel_speed_3,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic signed [15:0]    target_left,
    input  logic signed [15:0]    target_right,
    input  logic signed [15:0]    measured_speed,
    input  logic signed [15:0]    measured_yaw,
    input  logic                  watchdog_tripped,
    output int                    fail_count,
    output int                    pending_count
);

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] speed;
        logic signed [15:0] yaw;
        logic               trip;
    } drive_result_t;

    drive_result_t expected_results[$];

    logic [15:0] timeout_ms;
    logic [14:0] speed_step;
    logic [14:0] yaw_step;
    logic [11:0] track_mm;
    logic [14:0] wheel_max;
    logic [3:0]  left_mask;

    int          held_speed;
    int          held_yaw;
    logic [31:0] stamp;
    logic        seen;
    int          ramp_s;
    int          ramp_y;
    logic        trip;
    int          last_left;
    int          last_right;
    int          last_speed;
    int          last_yaw;

    assign pending_count = expected_results.size();

    function automatic int slew(int cur, int want, int step);
        int d;
        d = want - cur;
        if (d > step) return cur + step;
        if (d < -step) return cur - step;
        return want;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic run_tick(logic [31:0] now, logic signed [15:0] w [4]);
        logic [31:0] age;
        logic        stale;
        int          want_s;
        int          want_y;
        longint      l;
        longint      r;
        longint      al;
        longint      ar;
        longint      peak;
        longint      sum_l;
        longint      sum_r;
        longint      a;
        longint      b;
        longint      den;
        longint      y;
        int          n_l;
        int          n_r;
        age = now - stamp;
        stale = !seen || age > {16'd0, timeout_ms};
        want_s = 0;
        want_y = 0;
        sum_l = 0;
        sum_r = 0;
        n_l = 0;
        n_r = 0;
        if (stale)
        begin
            if (!trip)
            begin
                ramp_s = 0;
                ramp_y = 0;
            end
            trip = 1'b1;
        end
        else
        begin
            trip = 1'b0;
            want_s = held_speed;
            want_y = held_yaw;
        end
        ramp_s = slew(ramp_s, want_s, int'(speed_step));
        ramp_y = slew(ramp_y, want_y, int'(yaw_step));
        l = longint'(ramp_s) * 2000 - longint'(ramp_y) * longint'(track_mm);
        r = longint'(ramp_s) * 2000 + longint'(ramp_y) * longint'(track_mm);
        al = l < 0 ? -l : l;
        ar = r < 0 ? -r : r;
        peak = al > ar ? al : ar;
        if (peak > longint'(wheel_max) * 2000)
        begin
            last_left = int'((l * longint'(wheel_max)) / peak);
            last_right = int'((r * longint'(wheel_max)) / peak);
        end
        else
        begin
            last_left = int'(l / 2000);
            last_right = int'(r / 2000);
        end
        for (int i = 0; i < 4; i++)
        begin
            if (left_mask[i])
            begin
                sum_l += w[i];
                n_l++;
            end
            else
            begin
                sum_r += w[i];
                n_r++;
            end
        end
        if (n_l == 0) n_l = 1;
        if (n_r == 0) n_r = 1;
        a = sum_l * n_r;
        b = sum_r * n_l;
        den = longint'(n_l) * n_r;
        last_speed = int'((a + b) / (2 * den));
        if (track_mm == 0)
            last_yaw = 0;
        else
        begin
            y = ((b - a) * 1000) / (den * longint'(track_mm));
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            last_yaw = int'(y);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] w [4];
        drive_result_t      res;
        drive_result_t      want;
        if (!rst_n)
        begin
            timeout_ms = TIMEOUT_RST;
            speed_step = SPEED_STEP_RST;
            yaw_step = YAW_STEP_RST;
            track_mm = TRACK_RST;
            wheel_max = WHEEL_MAX_RST;
            left_mask = LEFT_MASK_RST;
            held_speed = 0;
            held_yaw = 0;
            stamp = '0;
            seen = 1'b0;
            ramp_s = 0;
            ramp_y = 0;
            trip = 1'b1;
            last_left = 0;
            last_right = 0;
            last_speed = 0;
            last_yaw = 0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_TIMEOUT:    timeout_ms = cfg_data[15:0];
                    REG_SPEED_STEP: speed_step = cfg_data[14:0];
                    REG_YAW_STEP:   yaw_step = cfg_data[14:0];
                    REG_TRACK:      track_mm = cfg_data[11:0];
                    REG_WHEEL_MAX:  wheel_max = cfg_data[14:0];
                    REG_LEFT_MASK:  left_mask = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                res = '{target_left, target_right, measured_speed, measured_yaw,
                        watchdog_tripped};
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.left !== want.left) report("target_left", res.left, want.left);
                    if (res.right !== want.right)
                        report("target_right", res.right, want.right);
                    if (res.speed !== want.speed)
                        report("measured_speed", res.speed, want.speed);
                    if (res.yaw !== want.yaw) report("measured_yaw", res.yaw, want.yaw);
                    if (res.trip !== want.trip)
                        report("watchdog_tripped", res.trip, want.trip);
                end
            end
            if (in_valid && in_ready)
            begin
                w[0] = wheel_speed_0;
                w[1] = wheel_speed_1;
                w[2] = wheel_speed_2;
                w[3] = wheel_speed_3;
                case (op_t'(operation))
                    OP_TICK: run_tick(now_ms, w);
                    OP_SET:
                    begin
                        held_speed = cmd_speed;
                        held_yaw = cmd_yaw;
                        stamp = now_ms;
                        seen = 1'b1;
                    end
                    OP_STOP:
                    begin
                        held_speed = 0;
                        held_yaw = 0;
                        ramp_s = 0;
                        ramp_y = 0;
                        last_left = 0;
                        last_right = 0;
                    end
                    default: ;
                endcase
                want.left = last_left[15:0];
                want.right = last_right[15:0];
                want.speed = last_speed[15:0];
                want.yaw = last_yaw[15:0];
                want.trip = trip;
                expected_results.push_back(want);
            end
        end
    end

endmodule

// ===== test/tb_diff_drive_slew_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_slew_mixer
// Drives directed and random set, stop, nop and tick items through the slew
// mixer across several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_diff_drive_slew_mixer;
    import dds_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            operation = OP_TICK;
    logic signed [15:0]    cmd_speed = '0;
    logic signed [15:0]    cmd_yaw = '0;
    logic [31:0]           now_ms = '0;
    logic signed [15:0]    wheel_speed_0 = '0;
    logic signed [15:0]    wheel_speed_1 = '0;
    logic signed [15:0]    wheel_speed_2 = '0;
    logic signed [15:0]    wheel_speed_3 = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [15:0]    target_left;
    logic signed [15:0]    target_right;
    logic signed [15:0]    measured_speed;
    logic signed [15:0]    measured_yaw;
    logic                  watchdog_tripped;
    int                    fail_count;
    int                    pending_count;
    logic                  calm = 1'b0;
    logic [31:0]           clock_ms = '0;

    always #5 clk = ~clk;

    diff_drive_slew_mixer dut (.*);
    dds_checker checker_i (.*);

    always @(posedge clk)
    begin
        int n;
        if (calm || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n - 1) @(posedge clk);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send(op_t op, logic [15:0] spd, logic [15:0] yaw, logic [31:0] now,
                        logic [63:0] wheels);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        cmd_speed <= spd;
        cmd_yaw <= yaw;
        now_ms <= now;
        {wheel_speed_3, wheel_speed_2, wheel_speed_1, wheel_speed_0} <= wheels;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int k;
        k = $urandom_range(0, 19);
        clock_ms = clock_ms + $urandom_range(0, 40);
        if (k == 0)
            clock_ms = clock_ms + $urandom_range(0, 3000);
        if (k < 3)
            send(OP_SET, pick16(), pick16(), clock_ms, 64'($urandom));
        else if (k == 3)
            send(OP_STOP, pick16(), pick16(), $urandom, 64'($urandom));
        else if (k == 4)
            send(OP_NOP, pick16(), pick16(), $urandom, {$urandom, $urandom});
        else if (k == 5)
            send(OP_TICK, pick16(), pick16(), $urandom, {$urandom, $urandom});
        else
            send(OP_TICK, pick16(), pick16(), clock_ms,
                 {pick16(), pick16(), pick16(), pick16()});
    endtask

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(OP_TICK, 16'h0, 16'h0, 32'd0, 64'h0);
        send(OP_SET, 16'h7fff, 16'h8000, 32'hffff_fff0, 64'h0);
        send(OP_TICK, 16'h0, 16'h0, 32'h0000_0010, {4{16'h7fff}});
        send(OP_TICK, 16'h0, 16'h0, 32'h0000_0020, {4{16'h8000}});
        send(OP_TICK, 16'h0, 16'h0, 32'h0000_0030, {16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
        send(OP_TICK, 16'h0, 16'h0, 32'h0000_1000, 64'h0);
        send(OP_TICK, 16'h0, 16'h0, 32'h0000_1001, 64'h0);
        send(OP_SET, 16'd300, 16'hff00, 32'h0000_1002, 64'h0);
        send(OP_STOP, 16'h0, 16'h0, 32'h0, 64'h0);
        send(OP_TICK, 16'h0, 16'h0, 32'h0000_1003, 64'h1234_5678_9abc_def0);
        send(OP_NOP, 16'hffff, 16'hffff, 32'hffff_ffff, {4{16'hffff}});
        drain();
        write_reg(REG_TRACK, 16'd0);
        write_reg(REG_WHEEL_MAX, 16'd0);
        write_reg(REG_LEFT_MASK, 16'd0);
        write_reg(REG_SPEED_STEP, 16'h7fff);
        write_reg(REG_YAW_STEP, 16'h7fff);
        write_reg(REG_TIMEOUT, 16'hffff);
        clock_ms = 32'hffff_ff00;
        repeat (10) random_item();
        drain();
        write_reg(REG_TRACK, 16'hfff);
        write_reg(REG_WHEEL_MAX, 16'h7fff);
        write_reg(REG_LEFT_MASK, 16'hf);
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_SPEED_STEP, 16'd0);
        write_reg(REG_YAW_STEP, 16'd0);
        repeat (10) random_item();
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_TIMEOUT, 16'($urandom_range(20, 200)));
            write_reg(REG_SPEED_STEP, 16'($urandom_range(1, 3000)));
            write_reg(REG_YAW_STEP, 16'($urandom_range(1, 5000)));
            write_reg(REG_TRACK, 16'($urandom_range(0, 4095)));
            write_reg(REG_WHEEL_MAX, 16'($urandom_range(0, 32767)));
            write_reg(REG_LEFT_MASK, 16'($urandom_range(0, 15)));
            if (phase == 5)
                calm = 1'b1;
            repeat (150) random_item();
            drain();
        end
        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
